// ===== sv/pfad_pkg.sv =====
// Shared types and constants of the feedback servo angle decoder.
// Holds the beat structs, register codes and the sequencer state type.
// Depends on nothing.
package pfad_pkg;

  localparam int CH_W      = 2;
  localparam int TICK_IN_W = 32;
  localparam int DUTY_W    = 16;
  localparam int ANGLE_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // register indexes of the write port
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_MIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX = 1'b1;

  // 0.029 and 0.971 in Q0.16
  localparam logic [CFG_W-1:0] DUTY_MIN_RESET = 16'd1901;
  localparam logic [CFG_W-1:0] DUTY_MAX_RESET = 16'd63635;

  typedef struct packed {
    logic [CH_W-1:0]      channel;
    logic                 level;
    logic [TICK_IN_W-1:0] tick;
  } in_beat_t;

  typedef struct packed {
    logic [CH_W-1:0]    channel_out;
    logic [DUTY_W-1:0]  duty;
    logic [ANGLE_W-1:0] angle;
  } out_beat_t;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_READ    = 7'b0000010,
    ST_CHK     = 7'b0000100,
    ST_DIV     = 7'b0001000,
    ST_ANG_SET = 7'b0010000,
    ST_ANG     = 7'b0100000,
    ST_OUT     = 7'b1000000
  } state_t;

endpackage

// ===== sv/pwm_feedback_angle_decoder.sv =====
// Top level of the feedback servo angle decoder: edge timestamps in, duty and angle out.
// Uses pfad_pkg for beat structs, register codes and state type.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one edge event per beat:
//   feedback line, new level and a free-running tick. Each event yields exactly
//   one output beat (out_valid/out_ready/out_data) with that line's stored duty
//   (Q0.16) and its angle, the duty clamped to [duty_min, duty_max] and scaled
//   to 0..65535. Registers are written through cfg_we/cfg_index/cfg_data.
//   The duty divider runs only on a rising edge with a nonzero, unsaturated
//   period; the two restoring dividers take FRAC_BITS steps for the duty and
//   16 steps for the angle. One event is in work at a time, so the next event
//   can be taken in the cycle after the output load.
//   Per-line state sits in two small synchronous RAMs (tick pair and duty)
//   with a registered read; each event reads, updates and writes back its entry.
//   Reset clears the per-entry valid bits, so all state reads as zero and the
//   registers take their reset values at once; no clearing pass is needed.
//   A stalled receiver holds the output register; the next event is still
//   accepted and waits before its own output load until the beat is taken.
module pwm_feedback_angle_decoder #(
  parameter int CHANNELS  = 4,
  parameter int TICK_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  pfad_pkg::in_beat_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output pfad_pkg::out_beat_t               out_data,
  input  logic                              cfg_we,
  input  logic [pfad_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pfad_pkg::CFG_W-1:0]        cfg_data
);

  localparam int AW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CW        = (FRAC_BITS > pfad_pkg::CFG_W) ? FRAC_BITS : pfad_pkg::CFG_W;
  localparam int STEPS_MAX = (FRAC_BITS > pfad_pkg::ANGLE_W) ? FRAC_BITS : pfad_pkg::ANGLE_W;
  localparam int CNT_W     = $clog2(STEPS_MAX);
  localparam int AW2       = 2 * pfad_pkg::ANGLE_W;

  // configuration registers
  logic [pfad_pkg::CFG_W-1:0] duty_min;
  logic [pfad_pkg::CFG_W-1:0] duty_max;

  // state memories: {pulse_start, pulse_end} and duty per line
  logic [2*TICK_BITS-1:0] tick_mem [CHANNELS];
  logic [FRAC_BITS-1:0]   duty_mem [CHANNELS];
  logic [2*TICK_BITS-1:0] tick_rd;
  logic [FRAC_BITS-1:0]   duty_rd;
  logic [CHANNELS-1:0]    tick_vld;
  logic [CHANNELS-1:0]    duty_vld;

  pfad_pkg::state_t state;

  // event context
  logic [pfad_pkg::CH_W-1:0] ch_q;
  logic [AW-1:0]             addr_q;
  logic                      level_q;
  logic [TICK_BITS-1:0]      tick_q;
  logic                      in_range_q;

  // duty divider
  logic [TICK_BITS-1:0] high_q;
  logic [TICK_BITS-1:0] period_q;
  logic [TICK_BITS-1:0] rem;
  logic [FRAC_BITS-1:0] duty_new;
  logic [CNT_W-1:0]     cnt;

  // angle divider
  logic [pfad_pkg::ANGLE_W-1:0] den;
  logic [pfad_pkg::ANGLE_W-1:0] arem;
  logic [pfad_pkg::ANGLE_W-1:0] num;
  logic [pfad_pkg::ANGLE_W-1:0] ang_q;

  logic                 in_fire;
  logic                 in_range;
  logic [AW-1:0]        in_addr;
  logic                 out_load;
  logic [TICK_BITS-1:0] start_cur;
  logic [TICK_BITS-1:0] end_cur;
  logic [TICK_BITS:0]   div_sh;
  logic                 div_take;
  logic [TICK_BITS:0]   div_diff;
  logic [pfad_pkg::ANGLE_W:0] ang_sh;
  logic                       ang_take;
  logic [pfad_pkg::ANGLE_W:0] ang_diff;
  logic [CW-1:0]                d_ext;
  logic [CW-1:0]                min_ext;
  logic [CW-1:0]                max_ext;
  logic [CW-1:0]                d_clamp;
  logic [pfad_pkg::ANGLE_W-1:0] span;
  logic [AW2-1:0]               scaled;

  assign in_ready = (state == pfad_pkg::ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign in_range = (32'(in_data.channel) < CHANNELS);
  assign in_addr  = AW'(in_data.channel);
  assign out_load = (state == pfad_pkg::ST_OUT) && (!out_valid || out_ready);

  // entries never written read as zero
  assign start_cur = tick_vld[addr_q] ? tick_rd[2*TICK_BITS-1:TICK_BITS] : '0;
  assign end_cur   = tick_vld[addr_q] ? tick_rd[TICK_BITS-1:0] : '0;

  // one restoring step of the duty division
  assign div_sh   = {rem, 1'b0};
  assign div_take = (div_sh >= {1'b0, period_q});
  assign div_diff = div_sh - {1'b0, period_q};

  // one restoring step of the angle division
  assign ang_sh   = {arem, num[pfad_pkg::ANGLE_W-1]};
  assign ang_take = (ang_sh >= {1'b0, den});
  assign ang_diff = ang_sh - {1'b0, den};

  // clamp and scale by 65535 as (x << 16) - x
  assign d_ext   = CW'(duty_new);
  assign min_ext = CW'(duty_min);
  assign max_ext = CW'(duty_max);
  always_comb begin
    d_clamp = d_ext;
    if (d_clamp < min_ext) d_clamp = min_ext;
    if (d_clamp > max_ext) d_clamp = max_ext;
  end
  assign span   = pfad_pkg::ANGLE_W'(d_clamp - min_ext);
  assign scaled = {span, {pfad_pkg::ANGLE_W{1'b0}}} - AW2'(span);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_min <= pfad_pkg::DUTY_MIN_RESET;
      duty_max <= pfad_pkg::DUTY_MAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfad_pkg::REG_DUTY_MIN: duty_min <= cfg_data;
        pfad_pkg::REG_DUTY_MAX: duty_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // state memories: read at accept, write back the tick pair and the duty
  always_ff @(posedge clk) begin
    if (in_fire && in_range) begin
      tick_rd <= tick_mem[in_addr];
      duty_rd <= duty_mem[in_addr];
    end
    if (state == pfad_pkg::ST_READ) begin
      if (level_q) tick_mem[addr_q] <= {tick_q, end_cur};
      else         tick_mem[addr_q] <= {start_cur, tick_q};
    end
    if (state == pfad_pkg::ST_ANG_SET) begin
      duty_mem[addr_q] <= duty_new;
    end
  end

  // valid bits of the memory entries
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_vld <= '0;
      duty_vld <= '0;
    end else begin
      if (state == pfad_pkg::ST_READ)    tick_vld[addr_q] <= 1'b1;
      if (state == pfad_pkg::ST_ANG_SET) duty_vld[addr_q] <= 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pfad_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) out_valid <= 1'b0;
      unique case (state)
        pfad_pkg::ST_IDLE: begin
          if (in_fire) begin
            if (in_range) state <= pfad_pkg::ST_READ;
            else          state <= pfad_pkg::ST_OUT;
          end
        end
        pfad_pkg::ST_READ: state <= pfad_pkg::ST_CHK;
        pfad_pkg::ST_CHK: begin
          if (level_q && period_q != '0 && high_q < period_q) state <= pfad_pkg::ST_DIV;
          else                                                 state <= pfad_pkg::ST_ANG_SET;
        end
        pfad_pkg::ST_DIV: begin
          if (cnt == '0) state <= pfad_pkg::ST_ANG_SET;
        end
        pfad_pkg::ST_ANG_SET: begin
          if (duty_max <= duty_min) state <= pfad_pkg::ST_OUT;
          else                      state <= pfad_pkg::ST_ANG;
        end
        pfad_pkg::ST_ANG: begin
          if (cnt == '0) state <= pfad_pkg::ST_OUT;
        end
        pfad_pkg::ST_OUT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            state     <= pfad_pkg::ST_IDLE;
          end
        end
        default: state <= pfad_pkg::ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      pfad_pkg::ST_IDLE: begin
        if (in_fire) begin
          ch_q       <= in_data.channel;
          addr_q     <= in_addr;
          level_q    <= in_data.level;
          tick_q     <= TICK_BITS'(in_data.tick);
          in_range_q <= in_range;
          duty_new   <= '0;
          ang_q      <= '0;
        end
      end
      pfad_pkg::ST_READ: begin
        // modulo differences against the stored start
        high_q   <= end_cur - start_cur;
        period_q <= tick_q - start_cur;
        duty_new <= duty_vld[addr_q] ? duty_rd : '0;
      end
      pfad_pkg::ST_CHK: begin
        if (level_q && period_q != '0) begin
          if (high_q >= period_q) begin
            duty_new <= '1;
          end else begin
            rem      <= high_q;
            duty_new <= '0;
            cnt      <= CNT_W'(FRAC_BITS - 1);
          end
        end
      end
      pfad_pkg::ST_DIV: begin
        rem      <= div_take ? div_diff[TICK_BITS-1:0] : div_sh[TICK_BITS-1:0];
        duty_new <= {duty_new[FRAC_BITS-2:0], div_take};
        cnt      <= cnt - 1'b1;
      end
      pfad_pkg::ST_ANG_SET: begin
        ang_q <= '0;
        den   <= duty_max - duty_min;
        arem  <= scaled[AW2-1:pfad_pkg::ANGLE_W];
        num   <= scaled[pfad_pkg::ANGLE_W-1:0];
        cnt   <= CNT_W'(pfad_pkg::ANGLE_W - 1);
      end
      pfad_pkg::ST_ANG: begin
        arem  <= ang_take ? ang_diff[pfad_pkg::ANGLE_W-1:0]
                          : ang_sh[pfad_pkg::ANGLE_W-1:0];
        num   <= {num[pfad_pkg::ANGLE_W-2:0], 1'b0};
        ang_q <= {ang_q[pfad_pkg::ANGLE_W-2:0], ang_take};
        cnt   <= cnt - 1'b1;
      end
      pfad_pkg::ST_OUT: begin
        if (out_load) begin
          out_data.channel_out <= ch_q;
          out_data.duty        <= pfad_pkg::DUTY_W'(duty_new);
          out_data.angle       <= ang_q;
        end
      end
      default: ;
    endcase
  end

  // an accepted event goes to the memory read, or straight out when off range
  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == pfad_pkg::ST_READ || state == pfad_pkg::ST_OUT))
    else $error("accepted event took a wrong path");

  // an off-range line reports zero duty and angle
  a_off_range_zero: assert property (@(posedge clk) disable iff (rst)
    (out_load && !in_range_q) |=> (out_data.duty == '0 && out_data.angle == '0))
    else $error("off-range line reported nonzero result");

  // the angle remainder stays below the divisor
  a_ang_rem: assert property (@(posedge clk) disable iff (rst)
    (state == pfad_pkg::ST_ANG) |-> (arem < den))
    else $error("angle remainder out of range");

  // the duty remainder stays below the period
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == pfad_pkg::ST_DIV) |-> (rem < period_q))
    else $error("duty remainder out of range");

endmodule
